@@ hw/rtl/tmh_pkg.sv @@
// Shared types and constants for the timer min-heap block.
// Used by every module under hw/rtl but tmh_ram; depends on nothing.
`timescale 1ns / 1ps
package tmh_pkg;
   localparam int CAPACITY  = 64;
   localparam int ID_COUNT  = 256;
   localparam int TIME_BITS = 32;
   localparam int ID_BITS   = $clog2(ID_COUNT);
   localparam int ADDR_BITS = $clog2(CAPACITY);
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);

   // Request kinds as they arrive on the input channel.
   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_CANCEL = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_CANCEL,
      OP_TICK,
      OP_NOP
   } op_type;

   // One classified item as it waits in the queue.
   typedef struct packed {
      op_type               op;
      logic [ID_BITS-1:0]   id;
      logic [TIME_BITS-1:0] time_val;
   } item_type;

   // One heap slot.
   typedef struct packed {
      logic [TIME_BITS-1:0] expiry;
      logic [ID_BITS-1:0]   id;
   } entry_type;

   // One result item.
   typedef struct packed {
      logic                 status;
      logic                 fired;
      logic [ID_BITS-1:0]   fired_id;
      logic                 last;
      logic [CNT_BITS-1:0]  entry_count;
      logic [TIME_BITS-1:0] earliest_expire;
   } result_type;
endpackage

@@ hw/rtl/timer_min_heap_top.sv @@
// The heap sits in a RAM with a single read port.
// Throughput: one item at a time in the sequencer; a two-entry queue takes items meanwhile.
// Reset: synchronous, active high; clears count, queue and result register at once, then a
// pass over all ID_COUNT (256) ids clears the cancel marks before the first item is served.
// Top level of the timer min-heap; depends on tmh_pkg, tmh_front and tmh_engine.
`timescale 1ns / 1ps
module timer_min_heap_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // req_type
   input  logic [71:0] req_tdata,   // timer_id[7:0], new_expire[39:8], now_time[71:40]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser,   // status[0], fired[1]
   output logic [47:0] rsp_tdata    // fired_id[7:0], entry_count[14:8],
                                    // earliest_expire[46:15], zero[47]
);
   import tmh_pkg::*;

   logic       q_valid, q_ready;
   item_type   q_item;
   result_type res;

   tmh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_id     (req_tdata[7:0]),
      .req_expire (req_tdata[39:8]),
      .req_now    (req_tdata[71:40]),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_ready    (q_ready)
   );

   tmh_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_ready   (q_ready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (res)
   );

   // Pack the result item onto the stream.
   assign rsp_tlast = res.last;
   assign rsp_tuser = {res.fired, res.status};
   assign rsp_tdata = {1'b0, res.earliest_expire, res.entry_count, res.fired_id};
endmodule

@@ hw/rtl/tmh_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
module tmh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ hw/rtl/tmh_front.sv @@
// Front end: accepts request items, classifies them and queues them.
// Depends on tmh_pkg.
`timescale 1ns / 1ps
module tmh_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [1:0]                  req_tuser,
   input  logic [tmh_pkg::ID_BITS-1:0] req_id,
   input  logic [tmh_pkg::TIME_BITS-1:0] req_expire,
   input  logic [tmh_pkg::TIME_BITS-1:0] req_now,
   output logic                        q_valid,
   output tmh_pkg::item_type           q_item,
   input  logic                        q_ready
);
   import tmh_pkg::*;

   item_type  slot_ff [2];
   logic      wr_ptr_ff, wr_ptr_in;
   logic      rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   item_type  cls;
   logic      push, pop;

   // Classify the incoming item and keep only the time it needs.
   always_comb begin
      cls.id = req_id;
      case (req_tuser)
         REQ_ADD: begin
            cls.op       = OP_ADD;
            cls.time_val = req_expire;
         end
         REQ_CANCEL: begin
            cls.op       = OP_CANCEL;
            cls.time_val = req_expire;
         end
         REQ_TICK: begin
            cls.op       = OP_TICK;
            cls.time_val = req_now;
         end
         default: begin
            cls.op       = OP_NOP;
            cls.time_val = req_now;
         end
      endcase
   end

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != 2'd0);
   assign pop        = q_valid && q_ready;
   assign q_item     = slot_ff[rd_ptr_ff];

   // Two-entry queue pointers and fill level.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end
endmodule

@@ hw/rtl/tmh_engine.sv @@
// Back end: carries out add, cancel and tick on the heap and drives results.
// Depends on tmh_pkg and tmh_ram.
`timescale 1ns / 1ps
module tmh_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  tmh_pkg::item_type   q_item,
   output logic                q_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tmh_pkg::result_type rsp_data
);
   import tmh_pkg::*;

   localparam int IW = ADDR_BITS + 2;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_EMIT, S_UP_CHK, S_UP_CMP, S_TK_CHK, S_TK_LAST,
      S_SD_L, S_SD_R, S_SD_CMP, S_TK_POPPED, S_TK_END
   } state_type;

   state_type            state_ff, state_in;
   item_type             cur_ff, cur_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [ID_BITS-1:0]   clr_ff, clr_in;
   entry_type            root_ff, root_in;
   logic [ADDR_BITS-1:0] hole_ff, hole_in;
   entry_type            moving_ff, moving_in;
   entry_type            left_ff, left_in;
   logic                 have_r_ff, have_r_in;
   logic [ID_BITS-1:0]   pid_ff, pid_in;
   logic                 pdead_ff, pdead_in;
   logic                 pend_ff, pend_in;
   result_type           pend_res_ff, pend_res_in;
   logic                 em_status_ff, em_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_ff, rsp_in;

   logic                 we;
   logic [ADDR_BITS-1:0] waddr, raddr;
   entry_type            wdata, rdata;
   logic                 mk_we;
   logic [ID_BITS-1:0]   mk_waddr;
   logic                 mk_wdata, mk_rdata;
   logic                 out_free;
   logic [IW-1:0]        c_w, c1_w, cnt_w;
   logic [TIME_BITS-1:0] cur_exp;
   entry_type            child;
   logic [ADDR_BITS-1:0] cidx;

   tmh_ram #(.WIDTH($bits(entry_type)), .DEPTH(CAPACITY)) u_heap (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   // Cancel marks, one bit per id; always reads the mark of the current root.
   tmh_ram #(.WIDTH(1), .DEPTH(ID_COUNT)) u_marks (
      .clock (clock),
      .we    (mk_we),
      .waddr (mk_waddr),
      .wdata (mk_wdata),
      .raddr (root_ff.id),
      .rdata (mk_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign c_w      = {1'b0, hole_ff, 1'b1};
   assign c1_w     = c_w + IW'(1);
   assign cnt_w    = IW'(cnt_ff);
   assign cur_exp  = (cnt_ff == '0) ? '0 : root_ff.expiry;

   // Pick the smaller child; ties go to the left.
   always_comb begin
      if (have_r_ff && (rdata.expiry < left_ff.expiry)) begin
         child = rdata;
         cidx  = c1_w[ADDR_BITS-1:0];
      end else begin
         child = left_ff;
         cidx  = c_w[ADDR_BITS-1:0];
      end
   end

   // Next-state logic for the heap sequencer.
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      hole_in      = hole_ff;
      moving_in    = moving_ff;
      left_in      = left_ff;
      have_r_in    = have_r_ff;
      pid_in       = pid_ff;
      pdead_in     = pdead_ff;
      pend_in      = pend_ff;
      pend_res_in  = pend_res_ff;
      em_status_in = em_status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      q_ready      = 1'b0;
      we           = 1'b0;
      waddr        = hole_ff;
      wdata        = moving_ff;
      raddr        = '0;
      mk_we        = 1'b0;
      mk_waddr     = cur_ff.id;
      mk_wdata     = 1'b0;

      unique case (state_ff)
         // After reset, walk every cancel mark and clear it.
         S_CLEAR: begin
            mk_we    = 1'b1;
            mk_waddr = clr_ff;
            mk_wdata = 1'b0;
            clr_in   = clr_ff + ID_BITS'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_ready      = 1'b1;
               cur_in       = q_item;
               em_status_in = 1'b0;
               unique case (q_item.op)
                  OP_ADD: begin
                     if (cnt_ff == CNT_BITS'(CAPACITY)) begin
                        em_status_in = 1'b1;
                        state_in     = S_EMIT;
                     end else begin
                        hole_in  = cnt_ff[ADDR_BITS-1:0];
                        cnt_in   = cnt_ff + CNT_BITS'(1);
                        state_in = S_UP_CHK;
                     end
                  end
                  OP_CANCEL: begin
                     mk_we    = 1'b1;
                     mk_waddr = q_item.id;
                     mk_wdata = 1'b1;
                     state_in = S_EMIT;
                  end
                  OP_TICK: begin
                     pend_in  = 1'b0;
                     state_in = S_TK_CHK;
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.status          = em_status_ff;
               rsp_in.fired           = 1'b0;
               rsp_in.fired_id        = '0;
               rsp_in.last            = 1'b1;
               rsp_in.entry_count     = cnt_ff;
               rsp_in.earliest_expire = cur_exp;
               state_in               = S_IDLE;
            end
         end
         // Sift up: move parents down until the new key fits.
         S_UP_CHK: begin
            if (hole_ff == '0) begin
               we           = 1'b1;
               wdata.expiry = cur_ff.time_val;
               wdata.id     = cur_ff.id;
               mk_we        = 1'b1;
               mk_wdata     = 1'b0;
               state_in     = S_EMIT;
            end else begin
               raddr    = (hole_ff - ADDR_BITS'(1)) >> 1;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            we = 1'b1;
            if (rdata.expiry <= cur_ff.time_val) begin
               wdata.expiry = cur_ff.time_val;
               wdata.id     = cur_ff.id;
               mk_we        = 1'b1;
               mk_wdata     = 1'b0;
               state_in     = S_EMIT;
            end else begin
               wdata    = rdata;
               hole_in  = (hole_ff - ADDR_BITS'(1)) >> 1;
               state_in = S_UP_CHK;
            end
         end
         // Tick: pop the root while it has expired.
         S_TK_CHK: begin
            if ((cnt_ff == '0) || (root_ff.expiry > cur_ff.time_val)) begin
               state_in = S_TK_END;
            end else begin
               pid_in   = root_ff.id;
               pdead_in = mk_rdata;
               cnt_in   = cnt_ff - CNT_BITS'(1);
               if (cnt_in == '0) begin
                  state_in = S_TK_POPPED;
               end else begin
                  raddr    = cnt_in[ADDR_BITS-1:0];
                  state_in = S_TK_LAST;
               end
            end
         end
         S_TK_LAST: begin
            moving_in = rdata;
            hole_in   = '0;
            state_in  = S_SD_L;
         end
         // Sift down: read the left child, then the right slot, which is used only if present.
         S_SD_L: begin
            if (c_w >= cnt_w) begin
               we       = 1'b1;
               state_in = S_TK_POPPED;
            end else begin
               raddr    = c_w[ADDR_BITS-1:0];
               state_in = S_SD_R;
            end
         end
         S_SD_R: begin
            left_in   = rdata;
            have_r_in = (c1_w < cnt_w);
            raddr     = c1_w[ADDR_BITS-1:0];
            state_in  = S_SD_CMP;
         end
         S_SD_CMP: begin
            we = 1'b1;
            if (child.expiry < moving_ff.expiry) begin
               wdata    = child;
               hole_in  = cidx;
               state_in = S_SD_L;
            end else begin
               state_in = S_TK_POPPED;
            end
         end
         // A live pop is held back until it is known whether it is the final one.
         S_TK_POPPED: begin
            if (pdead_ff) begin
               state_in = S_TK_CHK;
            end else if (!pend_ff || out_free) begin
               if (pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pend_res_ff;
               end
               pend_in                     = 1'b1;
               pend_res_in.status          = 1'b0;
               pend_res_in.fired           = 1'b1;
               pend_res_in.fired_id        = pid_ff;
               pend_res_in.last            = 1'b0;
               pend_res_in.entry_count     = cnt_ff;
               pend_res_in.earliest_expire = cur_exp;
               state_in                    = S_TK_CHK;
            end
         end
         S_TK_END: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.status          = 1'b0;
               rsp_in.fired           = pend_ff;
               rsp_in.fired_id        = pend_ff ? pend_res_ff.fired_id : '0;
               rsp_in.last            = 1'b1;
               rsp_in.entry_count     = cnt_ff;
               rsp_in.earliest_expire = cur_exp;
               pend_in                = 1'b0;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The root copy follows every write to slot zero.
      root_in = (we && (waddr == '0)) ? wdata : root_ff;
   end

   // State, counters and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      root_ff      <= root_in;
      hole_ff      <= hole_in;
      moving_ff    <= moving_in;
      left_ff      <= left_in;
      have_r_ff    <= have_r_in;
      pid_ff       <= pid_in;
      pdead_ff     <= pdead_in;
      pend_res_ff  <= pend_res_in;
      em_status_ff <= em_status_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The heap never holds more than its capacity.
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(CAPACITY))
      else $error("heap count above capacity");

   // A pop that reads the last slot only happens on a non-empty heap.
   a_last_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TK_LAST) |-> (cnt_ff != '0))
      else $error("sift down on empty heap");

   // Items leave the queue only when the sequencer is idle.
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_ready |-> ((state_ff == S_IDLE) && q_valid))
      else $error("queue popped while busy");

   // A rejected add leaves the heap full.
   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EMIT) && em_status_ff) |-> (cnt_ff == CNT_BITS'(CAPACITY)))
      else $error("reject with room left");
endmodule
